// ----- sv/ecd_pkg.sv -----
// Shared types and constant reciprocals for the epoch seconds to calendar date pipeline.
package ecd_pkg;

  // Last valid instant is 9999-12-31 23:59:59; this bound and all above are rejected.
  localparam logic [63:0] MaxSecs = 64'd253402300800;

  localparam logic [21:0] ShiftDays = 22'd719468;
  localparam logic [9:0]  Div675    = 10'd675;
  localparam logic [17:0] EraDays   = 18'd146097;
  localparam logic [11:0] SecsHour  = 12'd3600;

  // Ceiling reciprocals: floor(n * M >> k) equals floor(n / d) for every n of the
  // stated width because k is the width of n plus the width of d.
  localparam logic [31:0] M675    = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
  localparam logic [22:0] MEra    = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
  localparam logic [23:0] M7      = 24'(((64'd1 << 26) + 64'd6) / 64'd7);
  localparam logic [17:0] M3600   = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] M60     = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam logic [18:0] M1460   = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] M36524  = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] M146096 = 19'(((64'd1 << 36) + 64'd146095) / 64'd146096);
  localparam logic [18:0] M365    = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [9:0]  M100    = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [11:0] M153    = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [11:0] M5      = 12'(((64'd1 << 14) + 64'd4) / 64'd5);

  localparam int DateLat  = 10;
  localparam int TimeLat  = 5;
  localparam int TimeDly  = DateLat - TimeLat;

  typedef struct packed {
    logic v;
    logic ok;
  } ctl_t;

  typedef struct packed {
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } ymd_t;

endpackage

// ----- sv/ecd_day_split.sv -----
// Range check and split of the seconds count into whole days and seconds of the day.
module ecd_day_split (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_v,
  input  logic signed [63:0]  x,
  output ecd_pkg::ctl_t       ctl,
  output logic [21:0]         days,
  output logic [16:0]         secs
);
  ecd_pkg::ctl_t ctl_a, ctl_b;
  logic [30:0] n_a, n_b;
  logic [6:0]  lo_a, lo_b;
  logic [62:0] p_b;
  logic [21:0] q_c;

  assign q_c = p_b[62:41];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
      ctl_b <= '0;
      ctl   <= '0;
    end else begin
      ctl_a.v  <= in_v;
      ctl_a.ok <= !x[63] && (64'(x) < ecd_pkg::MaxSecs);
      ctl_b    <= ctl_a;
      ctl      <= ctl_b;
    end
    // 86400 = 128 * 675: the low seven bits pass straight into the seconds.
    n_a  <= x[37:7];
    lo_a <= x[6:0];
    n_b  <= n_a;
    lo_b <= lo_a;
    p_b  <= 63'(n_a) * 63'(ecd_pkg::M675);
    days <= q_c;
    secs <= {10'(n_b - 31'(32'(q_c) * 32'(ecd_pkg::Div675))), lo_b};
  end

endmodule

// ----- sv/ecd_date.sv -----
// Era-based days-to-civil conversion, ten register stages.
module ecd_date (
  input  logic          clk,
  input  logic          rst,
  input  ecd_pkg::ctl_t ctl_in,
  input  logic [21:0]   days,
  output ecd_pkg::ctl_t ctl_out,
  output ecd_pkg::ymd_t ymd
);
  ecd_pkg::ctl_t ctl [ecd_pkg::DateLat-1];
  logic [21:0] sh1, sh2;
  logic [44:0] pe2;
  logic [4:0]  era3, era4, era5, era6, era7, era8, era9;
  logic [17:0] doe3, doe4, doe5, doe6, doe7, doe8;
  logic [36:0] a4, b4, c4, pt6;
  logic [17:0] t5;
  logic [8:0]  yoe7, yoe8, yoe9;
  logic [8:0]  doy8, doy9;
  logic [3:0]  mp9;
  logic [10:0] x5;
  logic [22:0] p153;
  logic [10:0] m153;
  logic [22:0] p5;
  logic [3:0]  mm;

  assign x5   = 11'(doy8) * 11'd5 + 11'd2;
  assign p153 = 23'(x5) * 23'(ecd_pkg::M153);
  assign m153 = 11'(mp9) * 11'd153 + 11'd2;
  assign p5   = 23'(m153) * 23'(ecd_pkg::M5);
  assign mm   = (mp9 < 4'd10) ? mp9 + 4'd3 : mp9 - 4'd9;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ecd_pkg::DateLat - 1; i++) ctl[i] <= '0;
      ctl_out <= '0;
    end else begin
      ctl[0] <= ctl_in;
      for (int i = 1; i < ecd_pkg::DateLat - 1; i++) ctl[i] <= ctl[i-1];
      ctl_out <= ctl[ecd_pkg::DateLat-2];
    end
    sh1  <= days + ecd_pkg::ShiftDays;
    sh2  <= sh1;
    pe2  <= 45'(sh1) * 45'(ecd_pkg::MEra);
    era3 <= pe2[44:40];
    doe3 <= 18'(sh2 - 22'(23'(pe2[44:40]) * 23'(ecd_pkg::EraDays)));
    era4 <= era3;
    doe4 <= doe3;
    a4   <= 37'(doe3) * 37'(ecd_pkg::M1460);
    b4   <= 37'(doe3) * 37'(ecd_pkg::M36524);
    c4   <= 37'(doe3) * 37'(ecd_pkg::M146096);
    era5 <= era4;
    doe5 <= doe4;
    t5   <= doe4 - 18'(a4[36:29]) + 18'(b4[36:34]) - 18'(c4[36]);
    era6 <= era5;
    doe6 <= doe5;
    pt6  <= 37'(t5) * 37'(ecd_pkg::M365);
    era7 <= era6;
    doe7 <= doe6;
    yoe7 <= pt6[35:27];
    era8 <= era7;
    doe8 <= doe7;
    yoe8 <= yoe7;
    era9 <= era8;
    yoe9 <= yoe8;
    doy8 <= 9'(doe7 - 18'(yoe7) * 18'd365 - 18'(yoe7[8:2])
            + 18'(19'(yoe7) * 19'(ecd_pkg::M100) >> 16));
    doy9 <= doy8;
    mp9  <= p153[22:19];
    ymd.day   <= 5'(doy9 - p5[22:14] + 9'd1);
    ymd.month <= mm;
    ymd.year  <= 14'(yoe9) + 14'(era9) * 14'd400 + ((mm <= 4'd2) ? 14'd1 : 14'd0);
  end

endmodule

// ----- sv/ecd_time.sv -----
// Weekday and time of day, padded to the latency of the date path.
module ecd_time (
  input  logic          clk,
  input  logic [21:0]   days,
  input  logic [16:0]   secs,
  output ecd_pkg::tod_t tod
);
  logic [22:0] d4_1, d4_2;
  logic [16:0] s1, s2;
  logic [46:0] pw2;
  logic [34:0] ph2;
  logic [2:0]  wd3, wd4;
  logic [4:0]  hr3, hr4;
  logic [11:0] soh3, soh4;
  logic [24:0] pm4;
  // The first entry is the last compute stage; the rest pad out to the date path.
  ecd_pkg::tod_t dly [ecd_pkg::TimeDly+1];

  always_ff @(posedge clk) begin
    d4_1 <= 23'(days) + 23'd4;
    s1   <= secs;
    d4_2 <= d4_1;
    s2   <= s1;
    pw2  <= 47'(d4_1) * 47'(ecd_pkg::M7);
    ph2  <= 35'(s1) * 35'(ecd_pkg::M3600);
    wd3  <= 3'(d4_2 - 23'(pw2[46:26]) * 23'd7);
    hr3  <= ph2[33:29];
    soh3 <= 12'(s2 - 17'(ph2[33:29]) * 17'(ecd_pkg::SecsHour));
    wd4  <= wd3;
    hr4  <= hr3;
    soh4 <= soh3;
    pm4  <= 25'(soh3) * 25'(ecd_pkg::M60);
    dly[0].weekday <= wd4;
    dly[0].hour    <= hr4;
    dly[0].minute  <= pm4[23:18];
    dly[0].second  <= 6'(soh4 - 12'(pm4[23:18]) * 12'd60);
    for (int i = 1; i <= ecd_pkg::TimeDly; i++) dly[i] <= dly[i-1];
  end

  assign tod = dly[ecd_pkg::TimeDly];

endmodule

// ----- sv/epoch_seconds_to_calendar_date.sv -----
// A start runs through the split, date and output stages to done; one item per cycle.
// Throughput: a new item may start in every cycle; busy is always low.
// The receiver cannot stall; each result shows on the ports for one cycle with done.
// The longest stages hold one multiplier of at most 31 by 32 bits on the day split.
// Reset is synchronous and clears the valid bits of every stage; payload is not reset.
module epoch_seconds_to_calendar_date (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] epoch_seconds,
  output logic               busy,
  output logic               done,
  output logic               ok,
  output logic [13:0]        year,
  output logic [3:0]         month,
  output logic [4:0]         day,
  output logic [2:0]         weekday,
  output logic [4:0]         hour,
  output logic [5:0]         minute,
  output logic [5:0]         second
);
  ecd_pkg::ctl_t ctl_s, ctl_d;
  logic [21:0]   days;
  logic [16:0]   secs;
  ecd_pkg::ymd_t ymd;
  ecd_pkg::tod_t tod;

  // The pipeline never holds an item back, so it is never busy.
  assign busy = 1'b0;

  // First three stages: the range check and the split into days and seconds.
  ecd_day_split u_split (
    .clk  (clk),
    .rst  (rst),
    .in_v (start),
    .x    (epoch_seconds),
    .ctl  (ctl_s),
    .days (days),
    .secs (secs)
  );

  // The date path carries the valid and range flags alongside its data.
  ecd_date u_date (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_s),
    .days    (days),
    .ctl_out (ctl_d),
    .ymd     (ymd)
  );

  // Time of day is cheaper and is delayed to line up with the date.
  ecd_time u_time (
    .clk  (clk),
    .days (days),
    .secs (secs),
    .tod  (tod)
  );

  // Output register: an out of range item reports all fields as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_d.v;
    end
    ok      <= ctl_d.ok;
    year    <= ctl_d.ok ? ymd.year : '0;
    month   <= ctl_d.ok ? ymd.month : '0;
    day     <= ctl_d.ok ? ymd.day : '0;
    weekday <= ctl_d.ok ? tod.weekday : '0;
    hour    <= ctl_d.ok ? tod.hour : '0;
    minute  <= ctl_d.ok ? tod.minute : '0;
    second  <= ctl_d.ok ? tod.second : '0;
  end

  a_zero_when_bad: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (year == 14'd0 && month == 4'd0 && day == 5'd0))
    else $error("rejected item carries a nonzero date");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    (done && ok) |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1
                      && year >= 14'd1970 && year <= 14'd9999))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    (done && ok) |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59
                      && weekday <= 3'd6))
    else $error("time field out of range");

endmodule

// ----- verif/epoch_seconds_to_calendar_date_test.sv -----
// Testbench for the epoch seconds to calendar date converter, checked against a local predictor.
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_date_test;

  // One converted date and time, laid out as the result ports of the block.
  typedef struct {
    logic        ok;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } civil_time_t;

  // The first instant after 9999-12-31 23:59:59 is rejected.
  localparam logic [63:0] LastValidSecs = 64'd253402300799;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic signed [63:0] epoch_seconds = '0;
  logic               busy;
  logic               done;
  logic               ok;
  logic [13:0]        year;
  logic [3:0]         month;
  logic [4:0]         day;
  logic [2:0]         weekday;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic [5:0]         second;

  epoch_seconds_to_calendar_date DUT (
    .clk(clk), .rst(rst), .start(start), .epoch_seconds(epoch_seconds),
    .busy(busy), .done(done), .ok(ok), .year(year), .month(month), .day(day),
    .weekday(weekday), .hour(hour), .minute(minute), .second(second)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items waiting to be driven, and dates expected back in order.
  logic [63:0]  pending_secs[$];
  civil_time_t  expected_dates[$];
  int           error_count = 0;
  int           items_sent = 0;
  int           dates_checked = 0;
  int           valid_seen = 0;
  bit           stimulus_done = 0;

  // Days-to-civil conversion on a 1970-based day count, as in the era method:
  // days are moved to a 0000-03-01 epoch and cut into 400-year eras.
  function automatic civil_time_t to_civil(logic [63:0] raw);
    civil_time_t r;
    logic [63:0] days, sod, shifted, era, yr;
    logic [31:0] doe, yoe, doy, mp, dd, mm;
    r = '{default: '0};
    if (raw[63]) return r;
    days = raw / 64'd86400;
    sod = raw % 64'd86400;
    shifted = days + 64'd719468;
    era = shifted / 64'd146097;
    doe = 32'(shifted - era * 64'd146097);
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    dd = doy - (153 * mp + 2) / 5 + 1;
    mm = (mp < 10) ? mp + 3 : mp - 9;
    yr = 64'(yoe) + era * 64'd400;
    if (mm <= 2) yr = yr + 1;
    if (yr < 1970 || yr > 9999) return r;
    r.ok = 1'b1;
    r.year = yr[13:0];
    r.month = mm[3:0];
    r.day = dd[4:0];
    r.weekday = 3'((days + 64'd4) % 64'd7);
    r.hour = 5'(sod / 64'd3600);
    r.minute = 6'((sod % 64'd3600) / 64'd60);
    r.second = 6'(sod % 64'd60);
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly timestamps in the valid span, spread over small, mid and full ranges,
  // with day boundaries, the end of the valid span, out of range values and raw noise mixed in.
  function automatic logic [63:0] random_secs();
    logic [63:0] d;
    case ($urandom_range(0, 9))
      0, 1, 2: return rand64() % (LastValidSecs + 1);
      3:       return 64'($urandom());
      4: begin
        // Around midnight on some day.
        d = (rand64() % 64'd2932897) * 64'd86400;
        return d + 64'($urandom_range(0, 3)) - 64'd2;
      end
      5:       return LastValidSecs - 64'($urandom_range(0, 200000));
      6:       return LastValidSecs + 64'($urandom_range(1, 100000000));
      7:       return rand64() | 64'h8000_0000_0000_0000;
      8:       return rand64();
      default: return 64'($urandom_range(0, 2000000));
    endcase
  endfunction

  // Driver: sends items in bursts, with random gaps between bursts.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_dates.push_back(to_civil(epoch_seconds));
        items_sent++;
      end
      if (start && busy) begin
        // Hold the item until the block takes it.
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_secs.size() > 0) begin
        epoch_seconds <= pending_secs.pop_front();
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every done strobe is checked against the oldest expected date.
  always @(posedge clk) begin
    civil_time_t exp_d;
    if (!rst && done) begin
      if (expected_dates.size() == 0) begin
        $error("Result arrived with no item outstanding");
        error_count++;
      end else begin
        exp_d = expected_dates.pop_front();
        dates_checked++;
        if (exp_d.ok) valid_seen++;
        if (ok !== exp_d.ok) begin
          $error("ok: expected %0d, got %0d", exp_d.ok, ok); error_count++;
        end
        if (year !== exp_d.year) begin
          $error("year: expected %0d, got %0d", exp_d.year, year); error_count++;
        end
        if (month !== exp_d.month) begin
          $error("month: expected %0d, got %0d", exp_d.month, month); error_count++;
        end
        if (day !== exp_d.day) begin
          $error("day: expected %0d, got %0d", exp_d.day, day); error_count++;
        end
        if (weekday !== exp_d.weekday) begin
          $error("weekday: expected %0d, got %0d", exp_d.weekday, weekday); error_count++;
        end
        if (hour !== exp_d.hour) begin
          $error("hour: expected %0d, got %0d", exp_d.hour, hour); error_count++;
        end
        if (minute !== exp_d.minute) begin
          $error("minute: expected %0d, got %0d", exp_d.minute, minute); error_count++;
        end
        if (second !== exp_d.second) begin
          $error("second: expected %0d, got %0d", exp_d.second, second); error_count++;
        end
      end
    end
  end

  initial begin
    int i;
    // Directed items: the epoch itself, day and leap-day boundaries, century
    // rules, the last valid instant and the first one past it, and negatives.
    pending_secs.push_back(64'd0);
    pending_secs.push_back(64'd59);
    pending_secs.push_back(64'd86399);
    pending_secs.push_back(64'd86400);
    pending_secs.push_back(64'd68169599);    // 1972-02-28 23:59:59
    pending_secs.push_back(64'd68169600);    // 1972-02-29
    pending_secs.push_back(64'd68256000);    // 1972-03-01
    pending_secs.push_back(64'd951782400);   // 2000-02-29
    pending_secs.push_back(64'd946684799);
    pending_secs.push_back(64'd4107542400);  // 2100-03-01, no leap day in 2100
    pending_secs.push_back(64'd4107456000);
    pending_secs.push_back(64'd2147483647);
    pending_secs.push_back(64'd2147483648);
    pending_secs.push_back(LastValidSecs);
    pending_secs.push_back(LastValidSecs + 1);
    pending_secs.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    pending_secs.push_back(64'h8000_0000_0000_0000);
    pending_secs.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    pending_secs.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_secs.push_back(64'h5555_5555_5555_5555);
    pending_secs.push_back(64'hFFFF_FFFF);
    for (i = 0; i < 1500; i++) pending_secs.push_back(random_secs());

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    wait (pending_secs.size() == 0 && !start);
    wait (expected_dates.size() == 0);
    repeat (30) @(posedge clk);
    $display("Converted %0d timestamps, %0d of them valid dates, across the full input range.",
             dates_checked, valid_seen);
    if (error_count == 0 && expected_dates.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Safety net against a block that stops answering.
  initial begin
    #2_000_000;
    $display("Timed out with %0d items still outstanding", expected_dates.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
